### design/qer_pkg.sv
// ----------------------------------------------------------------------------
// qer_pkg: shared types and constants for the quadratic evaluator and solver
// Fixed-point widths, register and mode codes, the pipeline record that
// travels down the cell chain, and small arithmetic helpers.
// ----------------------------------------------------------------------------
package qer_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COEF_W    = 32;

  // Square root: one result bit per cell.
  localparam int unsigned SQ_STEPS = 36;
  localparam int unsigned RAD_W    = 2 * SQ_STEPS;
  localparam int unsigned SQ_REM_W = SQ_STEPS + 3;

  // Root division: signed numerator, dividend, divisor and quotient widths.
  localparam int unsigned NUM_W     = SQ_STEPS + 1;
  localparam int unsigned DVD_W     = NUM_W + FRAC_BITS;
  localparam int unsigned DIV_W     = COEF_W + 1;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned DIV_STEPS = Q_W;
  localparam int unsigned TOP_W     = DVD_W - Q_W;
  localparam int unsigned CMP_W     = (TOP_W > DIV_W) ? TOP_W : DIV_W;

  localparam int unsigned PROD_W = 96;

  localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN    = 32'h8000_0000;
  localparam logic [31:0] COEF_A_RST = 32'(1) << FRAC_BITS;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef enum logic {
    MODE_EVAL  = 1'b0,
    MODE_ROOTS = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_t;

  // Record handed from cell to cell.
  typedef struct packed {
    mode_e                   mode;
    logic                    degen;
    logic                    dneg;
    logic                    dzero;
    logic [31:0]             poly;
    logic [31:0]             slope;
    logic                    ev_ovf;
    logic [RAD_W-1:0]        rad;
    logic [SQ_REM_W-1:0]     sq_rem;
    logic [SQ_STEPS-1:0]     sq_root;
    logic [1:0][DIV_W-1:0]   dv_rem;
    logic [1:0][Q_W-1:0]     dv_nq;
    logic [1:0]              dv_sat;
    logic [1:0]              dv_neg;
  } qer_pipe_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > 66'sd2147483647) begin
      r.val = SAT_MAX;
      r.ovf = 1'b1;
    end else if (v < -66'sd2147483648) begin
      r.val = SAT_MIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

### design/qer_front.sv
// ----------------------------------------------------------------------------
// qer_front: entry stages of the solver pipeline
// Multiplies, discriminant, and the complete evaluate-mode arithmetic.
// ----------------------------------------------------------------------------
module qer_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic signed [31:0]        x_value_i,
  input  qer_pkg::coef_t            coef_i,
  output logic                      out_valid_o,
  output qer_pkg::qer_pipe_t        out_o
);

  logic [5:0] v_d, v_q;
  logic       ld_a;

  // Stage A
  qer_pkg::mode_e     a_mode_q;
  logic signed [31:0] a_x_q;
  // Stage B
  qer_pkg::mode_e     b_mode_q;
  logic signed [31:0] b_x_q;
  logic signed [63:0] b_ax_d, b_ax_q;
  logic [63:0]        b_b2_d, b_b2_q, b_ac_d, b_ac_q;
  logic               b_degen_d, b_degen_q;
  logic [31:0]        bmag, amag, cmag;
  // Stage C
  qer_pkg::mode_e               c_mode_q;
  logic                         c_degen_q;
  logic signed [63:0]           u;
  logic [63:0]                  umag, axmag, sm;
  logic signed [65:0]           sm66;
  logic [62:0]                  c_umag_d, c_umag_q;
  logic [31:0]                  c_xmag_d, c_xmag_q;
  logic                         c_uneg_d, c_uneg_q;
  logic signed [65:0]           c_slope_d, c_slope_q;
  logic [66:0]                  b2e, ac4e;
  logic [qer_pkg::RAD_W-1:0]    c_rad_d, c_rad_q;
  logic                         c_dneg_d, c_dneg_q;
  // Stage D
  qer_pkg::mode_e               d_mode_q;
  logic                         d_degen_q, d_uneg_q, d_dneg_q;
  logic [63:0]                  d_pplo_d, d_pplo_q;
  logic [62:0]                  d_pphi_d, d_pphi_q;
  qer_pkg::sat_t                d_slope_d, d_slope_q;
  logic [qer_pkg::RAD_W-1:0]    d_rad_q;
  logic                         d_dzero_d, d_dzero_q;
  // Stage E
  qer_pkg::mode_e               e_mode_q;
  logic                         e_degen_q, e_uneg_q, e_dneg_q, e_dzero_q;
  logic [qer_pkg::PROD_W-1:0]   e_psum_d, e_psum_q;
  qer_pkg::sat_t                e_slope_q;
  logic [qer_pkg::RAD_W-1:0]    e_rad_q;
  // Stage F
  logic [qer_pkg::PROD_W-1:0]   pr;
  logic                         big;
  logic signed [65:0]           v66, pv;
  qer_pkg::sat_t                ps;
  qer_pkg::qer_pipe_t           f_d, f_q;

  assign ld_a       = en_i | ~v_q[0];
  assign in_ready_o = ld_a;

  always_comb begin
    v_d = v_q;
    if (ld_a) begin
      v_d[0] = in_valid_i;
    end
    if (en_i) begin
      v_d[5:1] = v_q[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Stage B: the three products of the coefficients and x.
  always_comb begin
    amag      = qer_pkg::mag32(coef_i.a);
    bmag      = qer_pkg::mag32(coef_i.b);
    cmag      = qer_pkg::mag32(coef_i.c);
    b_ax_d    = 64'(coef_i.a) * 64'(a_x_q);
    b_b2_d    = 64'(bmag) * 64'(bmag);
    b_ac_d    = 64'(amag) * 64'(cmag);
    b_degen_d = (a_mode_q == qer_pkg::MODE_ROOTS) && (coef_i.a == '0);
  end

  // Stage C: inner term a*x + b, slope, and the discriminant.
  always_comb begin
    u         = b_ax_q + (64'(coef_i.b) <<< qer_pkg::FRAC_BITS);
    umag      = u[63] ? 64'(-u) : 64'(u);
    c_umag_d  = umag[62:0];
    c_uneg_d  = u[63] ^ b_x_q[31];
    c_xmag_d  = qer_pkg::mag32(b_x_q);
    axmag     = b_ax_q[63] ? 64'(-b_ax_q) : 64'(b_ax_q);
    sm        = (axmag + (64'd1 << (qer_pkg::FRAC_BITS - 2))) >> (qer_pkg::FRAC_BITS - 1);
    sm66      = $signed({2'b00, sm});
    c_slope_d = (b_ax_q[63] ? -sm66 : sm66) + 66'(coef_i.b);
    b2e       = 67'(b_b2_q);
    ac4e      = 67'({b_ac_q, 2'b00});
    c_dneg_d  = 1'b0;
    if (coef_i.a[31] ^ coef_i.c[31]) begin
      c_rad_d = qer_pkg::RAD_W'(b2e + ac4e);
    end else if (b2e >= ac4e) begin
      c_rad_d = qer_pkg::RAD_W'(b2e - ac4e);
    end else begin
      c_rad_d  = qer_pkg::RAD_W'(b2e);
      c_dneg_d = 1'b1;
    end
  end

  // Stage D: |u|*|x| split into two partial products.
  always_comb begin
    d_pplo_d  = 64'(c_umag_q[31:0]) * 64'(c_xmag_q);
    d_pphi_d  = 63'(c_umag_q[62:32]) * 63'(c_xmag_q);
    d_slope_d = qer_pkg::sat32(c_slope_q);
    d_dzero_d = (c_rad_q == '0);
  end

  // Stage E: sum of partial products plus the rounding half.
  assign e_psum_d = qer_pkg::PROD_W'(d_pplo_q)
                  + qer_pkg::PROD_W'({d_pphi_q, 32'b0})
                  + (qer_pkg::PROD_W'(1) << (2 * qer_pkg::FRAC_BITS - 1));

  // Stage F: scale, add c, saturate.
  always_comb begin
    pr  = e_psum_q >> (2 * qer_pkg::FRAC_BITS);
    big = pr > (qer_pkg::PROD_W'(1) << 62);
    v66 = $signed({3'b000, pr[62:0]});
    pv  = (e_uneg_q ? -v66 : v66) + 66'(coef_i.c);
    ps  = qer_pkg::sat32(pv);
    f_d         = '0;
    f_d.mode    = e_mode_q;
    f_d.degen   = e_degen_q;
    f_d.dneg    = e_dneg_q;
    f_d.dzero   = e_dzero_q;
    f_d.poly    = big ? (e_uneg_q ? qer_pkg::SAT_MIN : qer_pkg::SAT_MAX) : ps.val;
    f_d.slope   = e_slope_q.val;
    f_d.ev_ovf  = big | ps.ovf | e_slope_q.ovf;
    f_d.rad     = e_rad_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      a_mode_q <= qer_pkg::mode_e'(mode_i);
      a_x_q    <= x_value_i;
    end
    if (en_i) begin
      b_mode_q  <= a_mode_q;
      b_x_q     <= a_x_q;
      b_ax_q    <= b_ax_d;
      b_b2_q    <= b_b2_d;
      b_ac_q    <= b_ac_d;
      b_degen_q <= b_degen_d;

      c_mode_q  <= b_mode_q;
      c_degen_q <= b_degen_q;
      c_umag_q  <= c_umag_d;
      c_xmag_q  <= c_xmag_d;
      c_uneg_q  <= c_uneg_d;
      c_slope_q <= c_slope_d;
      c_rad_q   <= c_rad_d;
      c_dneg_q  <= c_dneg_d;

      d_mode_q  <= c_mode_q;
      d_degen_q <= c_degen_q;
      d_uneg_q  <= c_uneg_q;
      d_dneg_q  <= c_dneg_q;
      d_pplo_q  <= d_pplo_d;
      d_pphi_q  <= d_pphi_d;
      d_slope_q <= d_slope_d;
      d_rad_q   <= c_rad_q;
      d_dzero_q <= d_dzero_d;

      e_mode_q  <= d_mode_q;
      e_degen_q <= d_degen_q;
      e_uneg_q  <= d_uneg_q;
      e_dneg_q  <= d_dneg_q;
      e_dzero_q <= d_dzero_q;
      e_psum_q  <= e_psum_d;
      e_slope_q <= d_slope_q;
      e_rad_q   <= d_rad_q;

      f_q <= f_d;
    end
  end

  assign out_valid_o = v_q[5];
  assign out_o       = f_q;

endmodule

### design/qer_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qer_sqrt_cell: one digit of the integer square root
// Brings in the next two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module qer_sqrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  qer_pkg::qer_pipe_t data_i,
  output logic               valid_o,
  output qer_pkg::qer_pipe_t data_o
);

  logic                           valid_q;
  logic [qer_pkg::SQ_REM_W-1:0]   rem_sh, trial;
  logic                           ge;
  qer_pkg::qer_pipe_t             data_d, data_q;

  always_comb begin
    rem_sh = {data_i.sq_rem[qer_pkg::SQ_REM_W-3:0], data_i.rad[qer_pkg::RAD_W-1 -: 2]};
    trial  = qer_pkg::SQ_REM_W'({data_i.sq_root, 2'b01});
    ge     = rem_sh >= trial;
    data_d         = data_i;
    data_d.sq_rem  = ge ? rem_sh - trial : rem_sh;
    data_d.sq_root = {data_i.sq_root[qer_pkg::SQ_STEPS-2:0], ge};
    data_d.rad     = data_i.rad << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/qer_prep.sv
// ----------------------------------------------------------------------------
// qer_prep: numerators and dividends for the root division
// Forms -b + sqrt D and -b - sqrt D, their magnitudes and signs, the scaled
// dividends, and the initial partial remainders.
// ----------------------------------------------------------------------------
module qer_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  qer_pkg::qer_pipe_t data_i,
  input  qer_pkg::coef_t     coef_i,
  output logic               valid_o,
  output qer_pkg::qer_pipe_t data_o
);

  logic [3:0]                          v_q;
  logic [31:0]                         amag;
  logic signed [qer_pkg::NUM_W-1:0]    sx, bx;
  logic signed [qer_pkg::NUM_W-1:0]    num_d [2];
  logic signed [qer_pkg::NUM_W-1:0]    num_q [2];
  logic [qer_pkg::NUM_W-1:0]           mag_d [2];
  logic [qer_pkg::NUM_W-1:0]           mag_q [2];
  logic [qer_pkg::DVD_W-1:0]           dvd_d [2];
  logic [qer_pkg::DVD_W-1:0]           dvd_q [2];
  logic [qer_pkg::DIV_W-1:0]           dvsr;
  logic [qer_pkg::TOP_W-1:0]           ntop  [2];
  qer_pkg::qer_pipe_t                  s1_q, s2_d, s2_q, s3_q, s4_d, s4_q;

  assign amag = qer_pkg::mag32(coef_i.a);
  assign sx   = $signed({1'b0, data_i.sq_root});
  assign bx   = qer_pkg::NUM_W'(coef_i.b);
  assign dvsr = qer_pkg::DIV_W'(amag) << 1;

  always_comb begin
    num_d[0] = sx - bx;
    num_d[1] = -bx - sx;
    s2_d = s1_q;
    s4_d = s3_q;
    for (int j = 0; j < 2; j++) begin
      mag_d[j]         = num_q[j][qer_pkg::NUM_W-1] ? qer_pkg::NUM_W'(-num_q[j])
                                                    : qer_pkg::NUM_W'(num_q[j]);
      s2_d.dv_neg[j]   = num_q[j][qer_pkg::NUM_W-1] ^ coef_i.a[31];
      dvd_d[j]         = (qer_pkg::DVD_W'(mag_q[j]) << qer_pkg::FRAC_BITS)
                       + qer_pkg::DVD_W'(amag);
      ntop[j]          = dvd_q[j][qer_pkg::DVD_W-1:qer_pkg::Q_W];
      // A quotient of 2^32 or more saturates whatever its sign.
      s4_d.dv_sat[j]   = qer_pkg::CMP_W'(ntop[j]) >= qer_pkg::CMP_W'(dvsr);
      s4_d.dv_rem[j]   = qer_pkg::DIV_W'(ntop[j]);
      s4_d.dv_nq[j]    = dvd_q[j][qer_pkg::Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= data_i;
      num_q <= num_d;
      s2_q  <= s2_d;
      mag_q <= mag_d;
      s3_q  <= s2_q;
      dvd_q <= dvd_d;
      s4_q  <= s4_d;
    end
  end

  assign valid_o = v_q[3];
  assign data_o  = s4_q;

endmodule

### design/qer_div_cell.sv
// ----------------------------------------------------------------------------
// qer_div_cell: one quotient bit of both root divisions
// Restoring division step, done side by side for the plus and minus numerators.
// ----------------------------------------------------------------------------
module qer_div_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  qer_pkg::qer_pipe_t          data_i,
  input  logic [qer_pkg::DIV_W-1:0]   dvsr_i,
  output logic                        valid_o,
  output qer_pkg::qer_pipe_t          data_o
);

  logic                        valid_q;
  logic [qer_pkg::DIV_W-1:0]   t [2];
  logic [1:0]                  ge;
  qer_pkg::qer_pipe_t          data_d, data_q;

  always_comb begin
    data_d = data_i;
    for (int j = 0; j < 2; j++) begin
      t[j]  = {data_i.dv_rem[j][qer_pkg::DIV_W-2:0], data_i.dv_nq[j][qer_pkg::Q_W-1]};
      ge[j] = t[j] >= dvsr_i;
      data_d.dv_rem[j] = ge[j] ? t[j] - dvsr_i : t[j];
      data_d.dv_nq[j]  = {data_i.dv_nq[j][qer_pkg::Q_W-2:0], ge[j]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/quadratic_eval_and_roots_unit.sv
// ----------------------------------------------------------------------------
// quadratic_eval_and_roots_unit: quadratic evaluator and real-root solver
// Signed Q16.16 coefficients a, b, c; evaluates value and slope at x or
// finds the real roots of a*x*x + b*x + c.
// ----------------------------------------------------------------------------
// Usage: write coef_a, coef_b and coef_c through the configuration port
// (indexes 0, 1, 2) while no transaction is in flight. Each input
// transaction carries a mode and an evaluation point and yields exactly one
// output transaction. In evaluate mode the result holds a*x*x+b*x+c and the
// slope 2*a*x+b; in roots mode it holds the root count and the roots.
// Throughput is one transaction per clock while the receiver does not stall.
// The input register is loaded at the accepting edge; then come 5 more entry
// stages (products, discriminant and the evaluate arithmetic), a chain of 36
// square-root cells, 4 dividend stages, a chain of 32 division cells and the
// output register. The division chain computes both roots side by side. When
// the receiver stalls, the whole pipeline holds; the entry stage still
// accepts a transaction if it is empty. Reset clears all valid bits and sets
// a to 1.0 and b and c to zero.
// ----------------------------------------------------------------------------
module quadratic_eval_and_roots_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [31:0] x_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] poly_value_o,
  output logic signed [31:0] slope_value_o,
  output logic [1:0]         root_count_o,
  output logic signed [31:0] first_root_o,
  output logic signed [31:0] second_root_o,
  output logic               overflow_flag_o,
  output logic               degenerate_flag_o
);

  qer_pkg::coef_t      coef_q;
  logic                en;
  logic                front_vld;
  qer_pkg::qer_pipe_t  front_data;

  logic [qer_pkg::SQ_STEPS:0]  sq_vld;
  qer_pkg::qer_pipe_t          sq_pipe [qer_pkg::SQ_STEPS+1];
  logic [qer_pkg::DIV_STEPS:0] dv_vld;
  qer_pkg::qer_pipe_t          dv_pipe [qer_pkg::DIV_STEPS+1];
  logic [qer_pkg::DIV_W-1:0]   dvsr;

  qer_pkg::qer_pipe_t  fin;
  logic [31:0]         root_val [2];
  logic [1:0]          root_ovf;

  logic                out_valid_q;
  logic [31:0]         poly_d, poly_q, slope_d, slope_q, r1_d, r1_q, r2_d, r2_q;
  logic [1:0]          cnt_d, cnt_q;
  logic                ovf_d, ovf_q, degen_d, degen_q;

  // Configuration registers; writes beyond the last index are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.a <= qer_pkg::COEF_A_RST;
      coef_q.b <= '0;
      coef_q.c <= '0;
    end else if (cfg_we_i) begin
      unique case (qer_pkg::reg_idx_e'(cfg_idx_i))
        qer_pkg::REG_COEF_A: coef_q.a <= cfg_wdata_i;
        qer_pkg::REG_COEF_B: coef_q.b <= cfg_wdata_i;
        qer_pkg::REG_COEF_C: coef_q.c <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output register is free or drained.
  assign en = ~out_valid_q | out_ready_i;

  qer_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .x_value_i   (x_value_i),
    .coef_i      (coef_q),
    .out_valid_o (front_vld),
    .out_o       (front_data)
  );

  // Square root of the discriminant, one root bit per cell.
  assign sq_vld[0]  = front_vld;
  assign sq_pipe[0] = front_data;

  for (genvar i = 0; i < qer_pkg::SQ_STEPS; i++) begin : g_sqrt
    qer_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[i]),
      .data_i  (sq_pipe[i]),
      .valid_o (sq_vld[i+1]),
      .data_o  (sq_pipe[i+1])
    );
  end

  qer_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld[qer_pkg::SQ_STEPS]),
    .data_i  (sq_pipe[qer_pkg::SQ_STEPS]),
    .coef_i  (coef_q),
    .valid_o (dv_vld[0]),
    .data_o  (dv_pipe[0])
  );

  // Division by 2a, one quotient bit per cell for both roots.
  assign dvsr = qer_pkg::DIV_W'(qer_pkg::mag32(coef_q.a)) << 1;

  for (genvar i = 0; i < qer_pkg::DIV_STEPS; i++) begin : g_div
    qer_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_vld[i]),
      .data_i  (dv_pipe[i]),
      .dvsr_i  (dvsr),
      .valid_o (dv_vld[i+1]),
      .data_o  (dv_pipe[i+1])
    );
  end

  assign fin = dv_pipe[qer_pkg::DIV_STEPS];

  // Signed, saturated roots from the unsigned quotients.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      if (fin.dv_sat[j]) begin
        root_val[j] = fin.dv_neg[j] ? qer_pkg::SAT_MIN : qer_pkg::SAT_MAX;
        root_ovf[j] = 1'b1;
      end else if (!fin.dv_neg[j] && (fin.dv_nq[j] > qer_pkg::SAT_MAX)) begin
        root_val[j] = qer_pkg::SAT_MAX;
        root_ovf[j] = 1'b1;
      end else if (fin.dv_neg[j] && (fin.dv_nq[j] > qer_pkg::SAT_MIN)) begin
        root_val[j] = qer_pkg::SAT_MIN;
        root_ovf[j] = 1'b1;
      end else begin
        root_val[j] = fin.dv_neg[j] ? 32'(-fin.dv_nq[j]) : fin.dv_nq[j];
        root_ovf[j] = 1'b0;
      end
    end
  end

  // Select the fields that the mode and the discriminant case report.
  always_comb begin
    poly_d  = '0;
    slope_d = '0;
    r1_d    = '0;
    r2_d    = '0;
    cnt_d   = qer_pkg::CNT_NONE;
    ovf_d   = 1'b0;
    degen_d = 1'b0;
    if (fin.mode == qer_pkg::MODE_EVAL) begin
      poly_d  = fin.poly;
      slope_d = fin.slope;
      ovf_d   = fin.ev_ovf;
    end else if (fin.degen) begin
      degen_d = 1'b1;
    end else if (fin.dneg) begin
      cnt_d = qer_pkg::CNT_NONE;
    end else if (fin.dzero) begin
      cnt_d = qer_pkg::CNT_ONE;
      r1_d  = root_val[0];
      ovf_d = root_ovf[0];
    end else begin
      cnt_d = qer_pkg::CNT_TWO;
      r1_d  = root_val[0];
      r2_d  = root_val[1];
      ovf_d = root_ovf[0] | root_ovf[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_vld[qer_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      poly_q  <= poly_d;
      slope_q <= slope_d;
      r1_q    <= r1_d;
      r2_q    <= r2_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      degen_q <= degen_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign poly_value_o      = poly_q;
  assign slope_value_o     = slope_q;
  assign root_count_o      = cnt_q;
  assign first_root_o      = r1_q;
  assign second_root_o     = r2_q;
  assign overflow_flag_o   = ovf_q;
  assign degenerate_flag_o = degen_q;

  // An empty output register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  a_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (root_count_o == qer_pkg::CNT_NONE ||
                     root_count_o == qer_pkg::CNT_ONE ||
                     root_count_o == qer_pkg::CNT_TWO))
    else $error("illegal root count");

  a_degen_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_flag_o |->
      root_count_o == qer_pkg::CNT_NONE && !overflow_flag_o && first_root_o == '0)
    else $error("degenerate transaction reports roots or overflow");

  a_second_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_count_o != qer_pkg::CNT_TWO |-> second_root_o == '0)
    else $error("second root set without two roots");

endmodule
